>>> src/vag_pkg.sv
// ---------------------------------------------------------------------------
// vag_pkg
// Shared widths, codes, payload types and coefficient tables for the VAG
// ADPCM decoder.
// ---------------------------------------------------------------------------
package vag_pkg;

   localparam int SAMPLE_INDEX_BITS     = 20;
   localparam int HISTORY_FRACTION_BITS = 18;
   localparam int OUT_IDX_W             = 20;

   localparam int HIST_W     = 40;
   localparam int ACC_W      = HIST_W + 3;
   localparam int COEF_W     = 8;
   localparam int PROD_W     = HIST_W + COEF_W;
   localparam int COEF_SHIFT = 6;
   localparam int TERM_EXP   = HISTORY_FRACTION_BITS + 12;
   localparam int TERM_SH_W  = $clog2(TERM_EXP + 1);
   localparam int RND_W      = HIST_W + 1 - HISTORY_FRACTION_BITS;

   localparam int PCM_POS_LIMIT = 32767;
   localparam int PCM_NEG_LIMIT = 32768;

   localparam logic [3:0] LOOP_START_MASK = 4'hE;
   localparam logic [3:0] LOOP_START_CODE = 4'h6;
   localparam logic [3:0] LOOP_END_CODE_A = 4'h3;
   localparam logic [3:0] LOOP_END_CODE_B = 4'h7;
   localparam int         LOOP_PAD        = 28;

   localparam logic [3:0] FILTER_NONE  = 4'd0;
   localparam logic [3:0] FILTER_ONE   = 4'd1;
   localparam logic [3:0] FILTER_TWO   = 4'd2;
   localparam logic [3:0] FILTER_THREE = 4'd3;
   localparam logic [3:0] FILTER_FOUR  = 4'd4;

   localparam logic [3:0] POS_SHIFT_FILTER = 4'd0;
   localparam logic [3:0] POS_LOOP_FLAGS   = 4'd1;

   typedef logic [SAMPLE_INDEX_BITS-1:0] idx_type;

   typedef struct packed {
      logic [7:0] vag_byte;
      logic       sound_start;
   } vag_req_type;

   typedef struct packed {
      logic signed [15:0]     pcm_sample;
      logic [OUT_IDX_W-1:0]   sample_index;
      logic [OUT_IDX_W-1:0]   loop_start;
      logic [OUT_IDX_W-1:0]   loop_length;
      logic                   pair_last;
   } vag_rsp_type;

   typedef struct packed {
      logic       start;
      logic       clear;
      logic [3:0] nibble;
      logic [7:0] shift_filter;
   } pred_ctl_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] pcm;
   } pred_stat_type;

   typedef enum logic [1:0] {
      PRED_IDLE,
      PRED_MUL_ONE,
      PRED_MUL_TWO,
      PRED_ROUND
   } pred_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN_LO,
      ST_PUT_LO,
      ST_RUN_HI,
      ST_PUT_HI
   } top_state_type;

   function automatic logic signed [COEF_W-1:0] coef_one(input logic [3:0] filt);
      logic signed [COEF_W-1:0] k;
      case (filt)
         FILTER_ONE:   k = COEF_W'(60);
         FILTER_TWO:   k = COEF_W'(115);
         FILTER_THREE: k = COEF_W'(98);
         FILTER_FOUR:  k = COEF_W'(122);
         default:      k = '0;
      endcase
      return k;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_two(input logic [3:0] filt);
      logic signed [COEF_W-1:0] k;
      case (filt)
         FILTER_TWO:   k = -COEF_W'(52);
         FILTER_THREE: k = -COEF_W'(55);
         FILTER_FOUR:  k = -COEF_W'(60);
         default:      k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [OUT_IDX_W-1:0] fit_idx(input idx_type v);
      logic [OUT_IDX_W+SAMPLE_INDEX_BITS-1:0] wide;
      wide = {{OUT_IDX_W{1'b0}}, v};
      return wide[OUT_IDX_W-1:0];
   endfunction

endpackage

>>> src/vag_predictor.sv
// ---------------------------------------------------------------------------
// vag_predictor
// Two-tap ADPCM predictor around one shared multiplier, with the history
// registers, saturation and output rounding. One sample per start pulse.
// ---------------------------------------------------------------------------
module vag_predictor
   import vag_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pred_ctl_type  ctl,
   output pred_stat_type stat
);

   pred_state_type state_ff, state_in;
   logic signed [HIST_W-1:0] hist_one_ff, hist_one_in;
   logic signed [HIST_W-1:0] hist_two_ff, hist_two_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [15:0]       pcm_ff, pcm_in;
   logic                     done_ff, done_in;

   logic [3:0]               shift;
   logic [3:0]               filt;
   logic signed [HIST_W-1:0] mul_hist;
   logic signed [COEF_W-1:0] mul_coef;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  prod_scaled;
   logic signed [ACC_W-1:0]  sum;
   logic signed [HIST_W-1:0] sum_sat;
   logic signed [ACC_W-1:0]  term;
   logic [TERM_SH_W-1:0]     term_sh;
   logic [HIST_W:0]          hist_ext;
   logic [HIST_W:0]          mag;
   logic [HIST_W:0]          mag_half;
   logic [RND_W-1:0]         rnd;
   logic [RND_W-1:0]         rnd_neg;

   assign shift = ctl.shift_filter[3:0];
   assign filt  = ctl.shift_filter[7:4];

   // shared multiplier: first tap, then second tap
   assign mul_hist    = (state_ff == PRED_MUL_TWO) ? hist_two_ff : hist_one_ff;
   assign mul_coef    = (state_ff == PRED_MUL_TWO) ? coef_two(filt) : coef_one(filt);
   assign prod        = mul_hist * mul_coef;
   assign prod_scaled = ACC_W'($signed(prod[PROD_W-1:COEF_SHIFT]));
   assign sum         = acc_ff + prod_scaled;

   assign sum_sat = (sum[ACC_W-1:HIST_W-1] == {(ACC_W-HIST_W+1){sum[ACC_W-1]}})
                  ? sum[HIST_W-1:0]
                  : {sum[ACC_W-1], {(HIST_W-1){~sum[ACC_W-1]}}};

   assign term_sh = TERM_SH_W'(TERM_EXP) - TERM_SH_W'(shift);
   assign term    = ACC_W'($signed(ctl.nibble)) <<< term_sh;

   // round half away from zero
   assign hist_ext = {hist_one_ff[HIST_W-1], hist_one_ff};
   assign mag      = hist_one_ff[HIST_W-1] ? (~hist_ext + 1'b1) : hist_ext;
   assign mag_half = mag + ((HIST_W+1)'(1) << (HISTORY_FRACTION_BITS - 1));
   assign rnd      = RND_W'(mag_half >> HISTORY_FRACTION_BITS);
   assign rnd_neg  = ~rnd + 1'b1;

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      hist_one_in = hist_one_ff;
      hist_two_in = hist_two_ff;
      pcm_in      = pcm_ff;
      done_in     = 1'b0;
      unique case (state_ff)
         PRED_IDLE: begin
            if (ctl.start) begin
               acc_in   = term;
               state_in = PRED_MUL_ONE;
            end
         end
         PRED_MUL_ONE: begin
            acc_in   = sum;
            state_in = PRED_MUL_TWO;
         end
         PRED_MUL_TWO: begin
            hist_two_in = hist_one_ff;
            hist_one_in = sum_sat;
            state_in    = PRED_ROUND;
         end
         PRED_ROUND: begin
            if (hist_one_ff[HIST_W-1]) begin
               pcm_in = (rnd > RND_W'(PCM_NEG_LIMIT)) ? -16'sd32768 : $signed(rnd_neg[15:0]);
            end else begin
               pcm_in = (rnd > RND_W'(PCM_POS_LIMIT)) ? 16'sd32767 : $signed(rnd[15:0]);
            end
            done_in  = 1'b1;
            state_in = PRED_IDLE;
         end
         default: begin
            state_in = PRED_IDLE;
         end
      endcase
      if (ctl.clear) begin
         hist_one_in = '0;
         hist_two_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PRED_IDLE;
         done_ff     <= 1'b0;
         hist_one_ff <= '0;
         hist_two_ff <= '0;
      end else begin
         state_ff    <= state_in;
         done_ff     <= done_in;
         hist_one_ff <= hist_one_in;
         hist_two_ff <= hist_two_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pcm_ff <= pcm_in;
   end

   assign stat.done = done_ff;
   assign stat.pcm  = pcm_ff;

endmodule

>>> src/vag_adpcm_decoder.sv
// ---------------------------------------------------------------------------
// vag_adpcm_decoder
// Stream decoder for VAG ADPCM: 16-byte frames, two samples per data byte.
// ---------------------------------------------------------------------------
// One byte is taken per request. The shift/filter byte and the loop flag
// byte of each frame give no sample and leave the decoder ready for the
// next byte. A data byte gives two samples, low nibble first, and no new
// request is taken until both are loaded into the output register. Each
// sample runs through the shared multiplier twice (one pass per
// predictor tap), is then rounded, handed over to the decoder and
// loaded into the output register. A sample waits while the output
// stays stalled.
// The next request is taken while the last sample still sits in the
// output register. Assert sound_start on the first byte of a sound to
// clear the history, sample counter and loop values.
// ---------------------------------------------------------------------------
module vag_adpcm_decoder
   import vag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vag_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vag_rsp_type rsp_data
);

   top_state_type state_ff, state_in;
   logic [3:0]    pos_ff, pos_in;
   logic [7:0]    sf_ff, sf_in;
   logic [7:0]    byte_ff, byte_in;
   idx_type       cnt_ff, cnt_in;
   idx_type       begin_ff, begin_in;
   idx_type       span_ff, span_in;
   logic          rsp_valid_ff, rsp_valid_in;
   vag_rsp_type   rsp_ff, rsp_in;

   pred_ctl_type  pred_ctl;
   pred_stat_type pred_stat;

   logic                       req_accept;
   logic                       start_now;
   logic                       out_free;
   logic                       rsp_load;
   logic                       pair_last;
   logic [3:0]                 pos_eff;
   idx_type                    cnt_eff;
   idx_type                    begin_eff;
   idx_type                    span_eff;
   idx_type                    cnt_inc;
   idx_type                    begin_new;
   logic [SAMPLE_INDEX_BITS:0] span_wide;
   logic [SAMPLE_INDEX_BITS:0] span_diff;

   vag_predictor u_predictor (
      .clock (clock),
      .reset (reset),
      .ctl   (pred_ctl),
      .stat  (pred_stat)
   );

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign start_now  = req_accept && req_data.sound_start;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign pos_eff   = start_now ? '0 : pos_ff;
   assign cnt_eff   = start_now ? '0 : cnt_ff;
   assign begin_eff = start_now ? '0 : begin_ff;
   assign span_eff  = start_now ? '0 : span_ff;
   assign cnt_inc   = (cnt_ff == '1) ? cnt_ff : cnt_ff + idx_type'(1);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      sf_in     = sf_ff;
      byte_in   = byte_ff;
      cnt_in    = cnt_ff;
      begin_in  = begin_ff;
      span_in   = span_ff;
      rsp_load  = 1'b0;
      pair_last = 1'b0;
      begin_new = begin_eff;
      span_wide = '0;
      span_diff = '0;

      pred_ctl.start        = 1'b0;
      pred_ctl.clear        = start_now;
      pred_ctl.nibble       = byte_ff[7:4];
      pred_ctl.shift_filter = sf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cnt_in   = cnt_eff;
               begin_in = begin_eff;
               span_in  = span_eff;
               case (pos_eff)
                  POS_SHIFT_FILTER: begin
                     sf_in  = req_data.vag_byte;
                     pos_in = POS_LOOP_FLAGS;
                  end
                  POS_LOOP_FLAGS: begin
                     if ((req_data.vag_byte[3:0] & LOOP_START_MASK) == LOOP_START_CODE) begin
                        begin_new = cnt_eff;
                     end
                     begin_in = begin_new;
                     if (req_data.vag_byte[3:0] == LOOP_END_CODE_A ||
                         req_data.vag_byte[3:0] == LOOP_END_CODE_B) begin
                        span_wide = {1'b0, cnt_eff} + (SAMPLE_INDEX_BITS+1)'(LOOP_PAD);
                        span_diff = (span_wide >= {1'b0, begin_new})
                                  ? span_wide - {1'b0, begin_new} : '0;
                        span_in   = span_diff[SAMPLE_INDEX_BITS]
                                  ? '1 : span_diff[SAMPLE_INDEX_BITS-1:0];
                     end
                     pos_in = pos_eff + 4'd1;
                  end
                  default: begin
                     byte_in         = req_data.vag_byte;
                     pos_in          = pos_eff + 4'd1;
                     pred_ctl.start  = 1'b1;
                     pred_ctl.nibble = req_data.vag_byte[3:0];
                     state_in        = ST_RUN_LO;
                  end
               endcase
            end
         end
         ST_RUN_LO: begin
            if (pred_stat.done) begin
               state_in = ST_PUT_LO;
            end
         end
         ST_PUT_LO: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               cnt_in         = cnt_inc;
               pred_ctl.start = 1'b1;
               state_in       = ST_RUN_HI;
            end
         end
         ST_RUN_HI: begin
            if (pred_stat.done) begin
               state_in = ST_PUT_HI;
            end
         end
         ST_PUT_HI: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               pair_last = 1'b1;
               cnt_in    = cnt_inc;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.pcm_sample   = pred_stat.pcm;
      rsp_in.sample_index = fit_idx(cnt_ff);
      rsp_in.loop_start   = fit_idx(begin_ff);
      rsp_in.loop_length  = fit_idx(span_ff);
      rsp_in.pair_last    = pair_last;
      rsp_valid_in        = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sf_ff        <= '0;
         cnt_ff       <= '0;
         begin_ff     <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sf_ff        <= sf_in;
         cnt_ff       <= cnt_in;
         begin_ff     <= begin_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // predictor only finishes while a sample is awaited
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      pred_stat.done |-> (state_ff == ST_RUN_LO || state_ff == ST_RUN_HI))
      else $error("predictor done outside a run state");

   // sample counter never goes back within a sound
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !start_now |=> (cnt_ff >= $past(cnt_ff)))
      else $error("sample counter decreased without a sound start");

   // loop length never exceeds the samples seen plus one frame
   a_span_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, span_ff} <= ({1'b0, cnt_ff} + (SAMPLE_INDEX_BITS+1)'(LOOP_PAD))))
      else $error("loop length beyond sample count");

endmodule
